// File: sv/assert_macros.svh
// Assertion macros shared by the page table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

// File: sv/mlpt_pkg.sv
// Package for the multi-level page table: sizes, codes and types.
`timescale 1ns / 1ps

package mlpt_pkg;

  localparam int MaxLevels    = 4;
  localparam int MaxIndexBits = 8;
  localparam int NodePool     = 256;
  localparam int FrameBits    = 20;
  localparam int AddrBits     = 32;

  localparam int LevelBits     = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int NodeBits      = $clog2(NodePool);
  localparam int FreeBits      = NodeBits + 1;
  localparam int StoreAddrBits = NodeBits + MaxIndexBits;
  localparam int StoreDepth    = 1 << StoreAddrBits;
  localparam int PayloadBits   = (FrameBits > NodeBits) ? FrameBits : NodeBits;
  localparam int EntryBits     = PayloadBits + 1;

  localparam int CfgCountBits = 3;
  localparam int CfgWidthBits = 4;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 4;
  localparam int SumBits      = CfgWidthBits + LevelBits + 1;

  localparam logic [CfgIndexBits-1:0] CfgLevelCount = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgLevel0Bits = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgLevel1Bits = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgLevel2Bits = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgLevel3Bits = 3'd4;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncLookup = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_MAP  = 2'd1,
    STATUS_POOL    = 2'd2,
    STATUS_BAD_CFG = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                   valid;
    logic [PayloadBits-1:0] payload;
  } entry_t;

endpackage

// File: sv/multi_level_page_table_core.sv
// Multi-level page table core: walk, node allocation and entry store.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Radix page table of one to four levels held in a single-port-read,
// single-port-write synchronous entry store of 65536 x 21 bits (256 nodes of
// 256 entries). After reset the core clears every entry of the store with
// requests stalled; configuration writes are taken throughout. A request is
// walked level by level: each level costs one store read (ST_READ) and a
// check of the registered entry (ST_CHECK) that links a fresh node or writes
// the leaf, and ST_RESP then hands the result to the output register once
// that register is free. A miss or an exhausted pool ends the walk at the
// level where it occurs. A bad configuration skips the walk and goes straight
// to ST_RESP. The input stalls until the result is loaded, so no new request
// is taken before then. One request is walked at a time; the output register
// lets the next request be accepted while a result still waits downstream.
module multi_level_page_table_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [mlpt_pkg::CfgIndexBits-1:0]       cfg_index_i,
  input  logic [mlpt_pkg::CfgDataBits-1:0]        cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    func_i,
  input  logic [mlpt_pkg::AddrBits-1:0]           address_i,
  input  logic [mlpt_pkg::FrameBits-1:0]          frame_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              status_o,
  output logic [mlpt_pkg::FrameBits-1:0]          frame_out_o
);

  mlpt_pkg::state_e state_q, state_d;

  logic [mlpt_pkg::CfgCountBits-1:0] level_count_q;
  logic [mlpt_pkg::CfgWidthBits-1:0] level_bits_q [mlpt_pkg::MaxLevels];

  logic [mlpt_pkg::StoreAddrBits-1:0] clr_q;
  logic [mlpt_pkg::FreeBits-1:0]      next_free_q;
  logic [mlpt_pkg::LevelBits-1:0]     lvl_q;
  logic [mlpt_pkg::NodeBits-1:0]      node_q;
  logic [mlpt_pkg::AddrBits-1:0]      addr_q;
  logic                               func_q;
  logic [mlpt_pkg::FrameBits-1:0]     frame_q;
  logic [mlpt_pkg::StoreAddrBits-1:0] slot_q;
  mlpt_pkg::status_e                  res_status_q;
  logic [mlpt_pkg::FrameBits-1:0]     res_frame_q;
  logic                               out_valid_q;
  mlpt_pkg::status_e                  out_status_q;
  logic [mlpt_pkg::FrameBits-1:0]     out_frame_q;

  logic [mlpt_pkg::EntryBits-1:0]     mem_q [mlpt_pkg::StoreDepth];
  logic [mlpt_pkg::EntryBits-1:0]     mem_rdata_q;
  logic                               mem_we;
  logic [mlpt_pkg::StoreAddrBits-1:0] mem_waddr;
  logic [mlpt_pkg::EntryBits-1:0]     mem_wdata;
  logic [mlpt_pkg::StoreAddrBits-1:0] mem_raddr;

  logic                               in_accept;
  logic                               out_free;
  logic                               cfg_bad;
  logic [mlpt_pkg::SumBits-1:0]       width_sum;
  logic [mlpt_pkg::CfgWidthBits-1:0]  cur_w;
  logic [mlpt_pkg::MaxIndexBits-1:0]  idx;
  logic                               last_lvl;
  mlpt_pkg::entry_t                   rd_entry;
  logic                               child_ok;
  logic                               finish;
  logic                               descend;
  logic                               alloc;
  mlpt_pkg::status_e                  fin_status;
  logic [mlpt_pkg::FrameBits-1:0]     fin_frame;
  logic [mlpt_pkg::NodeBits-1:0]      next_node;

  assign in_stall_o  = (state_q != mlpt_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign frame_out_o = out_frame_q;

  always_comb begin
    cfg_bad   = (level_count_q == '0) ||
                (level_count_q > mlpt_pkg::CfgCountBits'(mlpt_pkg::MaxLevels));
    width_sum = '0;
    for (int l = 0; l < mlpt_pkg::MaxLevels; l++) begin
      if (mlpt_pkg::CfgCountBits'(l) < level_count_q) begin
        if ((level_bits_q[l] == '0) ||
            (level_bits_q[l] > mlpt_pkg::CfgWidthBits'(mlpt_pkg::MaxIndexBits))) begin
          cfg_bad = 1'b1;
        end
        width_sum = width_sum + mlpt_pkg::SumBits'(level_bits_q[l]);
      end
    end
    if (width_sum > mlpt_pkg::SumBits'(mlpt_pkg::AddrBits)) begin
      cfg_bad = 1'b1;
    end
  end

  assign cur_w    = level_bits_q[lvl_q];
  assign idx      = addr_q[mlpt_pkg::AddrBits-1 -: mlpt_pkg::MaxIndexBits]
                    >> (mlpt_pkg::CfgWidthBits'(mlpt_pkg::MaxIndexBits) - cur_w);
  assign mem_raddr = {node_q, idx};
  assign last_lvl = ({1'b0, lvl_q} + 1'b1) == mlpt_pkg::CfgCountBits'(level_count_q);
  assign rd_entry = mlpt_pkg::entry_t'(mem_rdata_q);
  assign child_ok = rd_entry.valid &&
                    (rd_entry.payload < mlpt_pkg::PayloadBits'(mlpt_pkg::NodePool));

  always_comb begin
    finish     = 1'b0;
    descend    = 1'b0;
    alloc      = 1'b0;
    fin_status = mlpt_pkg::STATUS_NO_MAP;
    fin_frame  = '0;
    next_node  = rd_entry.payload[mlpt_pkg::NodeBits-1:0];
    mem_we     = 1'b0;
    mem_waddr  = slot_q;
    mem_wdata  = '0;
    case (state_q)
      mlpt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      mlpt_pkg::ST_CHECK: begin
        if (last_lvl) begin
          finish = 1'b1;
          if (func_q == mlpt_pkg::FuncLookup) begin
            if (rd_entry.valid) begin
              fin_status = mlpt_pkg::STATUS_OK;
              fin_frame  = rd_entry.payload[mlpt_pkg::FrameBits-1:0];
            end
          end else begin
            mem_we     = 1'b1;
            mem_wdata  = {1'b1, mlpt_pkg::PayloadBits'(frame_q)};
            fin_status = mlpt_pkg::STATUS_OK;
            fin_frame  = frame_q;
          end
        end else if (child_ok) begin
          descend = 1'b1;
        end else if (func_q == mlpt_pkg::FuncLookup) begin
          finish = 1'b1;
        end else if (next_free_q >= mlpt_pkg::FreeBits'(mlpt_pkg::NodePool)) begin
          finish     = 1'b1;
          fin_status = mlpt_pkg::STATUS_POOL;
        end else begin
          descend   = 1'b1;
          alloc     = 1'b1;
          next_node = next_free_q[mlpt_pkg::NodeBits-1:0];
          mem_we    = 1'b1;
          mem_wdata = {1'b1, mlpt_pkg::PayloadBits'(next_free_q)};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlpt_pkg::ST_CLEAR: begin
        if (clr_q == '1) state_d = mlpt_pkg::ST_IDLE;
      end
      mlpt_pkg::ST_IDLE: begin
        if (in_accept) state_d = cfg_bad ? mlpt_pkg::ST_RESP : mlpt_pkg::ST_READ;
      end
      mlpt_pkg::ST_READ: begin
        state_d = mlpt_pkg::ST_CHECK;
      end
      mlpt_pkg::ST_CHECK: begin
        if (finish) state_d = mlpt_pkg::ST_RESP;
        else if (descend) state_d = mlpt_pkg::ST_READ;
      end
      mlpt_pkg::ST_RESP: begin
        if (out_free) state_d = mlpt_pkg::ST_IDLE;
      end
      default: begin
        state_d = mlpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mlpt_pkg::ST_CLEAR;
      clr_q         <= '0;
      next_free_q   <= mlpt_pkg::FreeBits'(1);
      level_count_q <= mlpt_pkg::CfgCountBits'(1);
      for (int l = 0; l < mlpt_pkg::MaxLevels; l++) begin
        level_bits_q[l] <= mlpt_pkg::CfgWidthBits'(mlpt_pkg::MaxIndexBits);
      end
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mlpt_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          mlpt_pkg::CfgLevelCount: level_count_q   <= cfg_data_i[mlpt_pkg::CfgCountBits-1:0];
          mlpt_pkg::CfgLevel0Bits: level_bits_q[0] <= cfg_data_i;
          mlpt_pkg::CfgLevel1Bits: level_bits_q[1] <= cfg_data_i;
          mlpt_pkg::CfgLevel2Bits: level_bits_q[2] <= cfg_data_i;
          mlpt_pkg::CfgLevel3Bits: level_bits_q[3] <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (alloc) begin
        next_free_q <= next_free_q + 1'b1;
      end
      if (state_q == mlpt_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q       <= func_i;
      addr_q       <= address_i;
      frame_q      <= frame_in_i;
      lvl_q        <= '0;
      node_q       <= '0;
      res_status_q <= mlpt_pkg::STATUS_BAD_CFG;
      res_frame_q  <= '0;
    end
    if (state_q == mlpt_pkg::ST_READ) begin
      slot_q <= mem_raddr;
    end
    if (descend) begin
      node_q <= next_node;
      lvl_q  <= lvl_q + 1'b1;
      addr_q <= addr_q << cur_w;
    end
    if (finish) begin
      res_status_q <= fin_status;
      res_frame_q  <= fin_frame;
    end
    if (state_q == mlpt_pkg::ST_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_frame_q  <= res_frame_q;
    end
  end

  `ASSERT_CLK(a_alloc_by_one, clk_i, rst_ni,
    (next_free_q != $past(next_free_q)) |->
      (next_free_q == mlpt_pkg::FreeBits'($past(next_free_q) + 1'b1)))
  `ASSERT_CLK(a_check_after_read, clk_i, rst_ni,
    (state_q == mlpt_pkg::ST_CHECK) |-> ($past(state_q) == mlpt_pkg::ST_READ))
  `ASSERT_CLK(a_result_from_resp, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(state_q) == mlpt_pkg::ST_RESP))

endmodule

// File: dv/multi_level_page_table_core_tb.sv
// Testbench for the page table core: directed and random walks checked by a scoreboard.
`timescale 1ns / 1ps

module multi_level_page_table_core_tb;

  localparam int unsigned NodeSize   = 1 << mlpt_pkg::MaxIndexBits;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned PhaseItems = 130;
  localparam logic [mlpt_pkg::CfgIndexBits-1:0] CfgSpare = mlpt_pkg::CfgLevel3Bits + 3'd1;

  typedef struct {
    mlpt_pkg::status_e                status;
    logic [mlpt_pkg::FrameBits-1:0]   frame;
  } walk_result_t;

  class walk_scoreboard;
    bit                                entry_valid   [mlpt_pkg::StoreDepth];
    bit [mlpt_pkg::PayloadBits-1:0]    entry_payload [mlpt_pkg::StoreDepth];
    int unsigned                       next_free_node;
    logic [mlpt_pkg::CfgCountBits-1:0] level_count;
    logic [mlpt_pkg::CfgWidthBits-1:0] level_bits [mlpt_pkg::MaxLevels];
    walk_result_t                      expected_walks [$];
    int unsigned                       failures;

    function new();
      next_free_node = 1;
      level_count    = 3'd1;
      foreach (level_bits[l]) level_bits[l] = 4'd8;
      failures       = 0;
    endfunction

    function void set_reg(logic [mlpt_pkg::CfgIndexBits-1:0] idx,
                          logic [mlpt_pkg::CfgDataBits-1:0] data);
      case (idx)
        mlpt_pkg::CfgLevelCount: level_count = data[mlpt_pkg::CfgCountBits-1:0];
        mlpt_pkg::CfgLevel0Bits: level_bits[0] = data;
        mlpt_pkg::CfgLevel1Bits: level_bits[1] = data;
        mlpt_pkg::CfgLevel2Bits: level_bits[2] = data;
        mlpt_pkg::CfgLevel3Bits: level_bits[3] = data;
        default: ;
      endcase
    endfunction

    function void walk_table(logic func, logic [mlpt_pkg::AddrBits-1:0] addr,
                             logic [mlpt_pkg::FrameBits-1:0] frame,
                             output walk_result_t res);
      int unsigned levels;
      int unsigned widths [mlpt_pkg::MaxLevels];
      int unsigned total;
      int unsigned shift;
      int unsigned idx;
      int unsigned slot;
      int unsigned node;
      res.status = mlpt_pkg::STATUS_BAD_CFG;
      res.frame  = '0;
      levels = level_count;
      total  = 0;
      node   = 0;
      if (levels < 1 || levels > mlpt_pkg::MaxLevels) return;
      for (int unsigned l = 0; l < levels; l++) begin
        widths[l] = level_bits[l];
        if (widths[l] < 1 || widths[l] > mlpt_pkg::MaxIndexBits) return;
        total += widths[l];
      end
      if (total > mlpt_pkg::AddrBits) return;
      total = 0;
      for (int unsigned l = 0; l < levels; l++) begin
        total += widths[l];
        shift = mlpt_pkg::AddrBits - total;
        idx   = 32'(addr >> shift) & ((32'd1 << widths[l]) - 32'd1);
        slot  = node * NodeSize + idx;
        if (l + 1 == levels) begin
          if (func == mlpt_pkg::FuncLookup) begin
            if (entry_valid[slot]) begin
              res.status = mlpt_pkg::STATUS_OK;
              res.frame  = entry_payload[slot];
            end else begin
              res.status = mlpt_pkg::STATUS_NO_MAP;
            end
          end else begin
            entry_payload[slot] = frame;
            entry_valid[slot]   = 1'b1;
            res.status = mlpt_pkg::STATUS_OK;
            res.frame  = frame;
          end
          return;
        end
        if (entry_valid[slot] && 32'(entry_payload[slot]) < mlpt_pkg::NodePool) begin
          node = 32'(entry_payload[slot]);
        end else if (func == mlpt_pkg::FuncLookup) begin
          res.status = mlpt_pkg::STATUS_NO_MAP;
          return;
        end else if (next_free_node >= mlpt_pkg::NodePool) begin
          res.status = mlpt_pkg::STATUS_POOL;
          return;
        end else begin
          node = next_free_node;
          next_free_node++;
          entry_payload[slot] = mlpt_pkg::PayloadBits'(node);
          entry_valid[slot]   = 1'b1;
        end
      end
      res.status = mlpt_pkg::STATUS_NO_MAP;
    endfunction

    function void note_request(logic func, logic [mlpt_pkg::AddrBits-1:0] addr,
                               logic [mlpt_pkg::FrameBits-1:0] frame);
      walk_result_t res;
      walk_table(func, addr, frame, res);
      expected_walks.push_back(res);
    endfunction

    function void check_response(logic [1:0] status, logic [mlpt_pkg::FrameBits-1:0] frame);
      walk_result_t want;
      if (expected_walks.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected response: status %0d frame 0x%05h", status, frame);
        return;
      end
      want = expected_walks.pop_front();
      if (status !== want.status || frame !== want.frame) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected status %0d frame 0x%05h, got status %0d frame 0x%05h",
                   want.status, want.frame, status, frame);
      end
    endfunction
  endclass

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [mlpt_pkg::CfgIndexBits-1:0] cfg_index_i = '0;
  logic [mlpt_pkg::CfgDataBits-1:0]  cfg_data_i  = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic                              func_i      = 1'b0;
  logic [mlpt_pkg::AddrBits-1:0]     address_i   = '0;
  logic [mlpt_pkg::FrameBits-1:0]    frame_in_i  = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [1:0]                        status_o;
  logic [mlpt_pkg::FrameBits-1:0]    frame_out_o;

  walk_scoreboard sb;
  int unsigned    send_idle_pct = 19;
  int unsigned    recv_idle_pct = 47;
  int unsigned    hold_requests = 0;
  int unsigned    holds_taken   = 0;
  int unsigned    hold_left     = 0;
  int unsigned    cycle_count   = 0;

  multi_level_page_table_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .address_i   (address_i),
    .frame_in_i  (frame_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .frame_out_o (frame_out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("multi_level_page_table_core verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(status_o, frame_out_o);
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_taken != hold_requests) begin
      holds_taken <= holds_taken + 1;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_req(logic func, logic [mlpt_pkg::AddrBits-1:0] addr,
                          logic [mlpt_pkg::FrameBits-1:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    address_i  <= addr;
    frame_in_i <= frame;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(func, addr, frame);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_walks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mlpt_pkg::CfgIndexBits-1:0] idx,
                           logic [mlpt_pkg::CfgDataBits-1:0] data, bit last);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    if (last) cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned levels, int unsigned w0, int unsigned w1,
                           int unsigned w2, int unsigned w3);
    write_reg(mlpt_pkg::CfgLevelCount, mlpt_pkg::CfgDataBits'(levels), 1'b0);
    write_reg(mlpt_pkg::CfgLevel0Bits, mlpt_pkg::CfgDataBits'(w0), 1'b0);
    write_reg(mlpt_pkg::CfgLevel1Bits, mlpt_pkg::CfgDataBits'(w1), 1'b0);
    write_reg(mlpt_pkg::CfgLevel2Bits, mlpt_pkg::CfgDataBits'(w2), 1'b0);
    write_reg(mlpt_pkg::CfgLevel3Bits, mlpt_pkg::CfgDataBits'(w3), 1'b1);
  endtask

  task automatic run_phase(int unsigned n_items);
    logic [mlpt_pkg::AddrBits-1:0] mapped [$];
    logic [mlpt_pkg::AddrBits-1:0] addr;
    int unsigned                   pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (mapped.size() != 0) addr = mapped[$urandom_range(mapped.size() - 1)];
      else addr = $urandom;
      if (pick < 35) begin
        if ($urandom_range(2) == 0) addr = $urandom;
        else addr = addr ^ ($urandom >> $urandom_range(31, 1));
        mapped.push_back(addr);
        send_req(mlpt_pkg::FuncInsert, addr, mlpt_pkg::FrameBits'($urandom));
      end else if (pick < 75) begin
        if ($urandom_range(3) == 0) addr = addr ^ ($urandom >> $urandom_range(31, 1));
        send_req(mlpt_pkg::FuncLookup, addr, mlpt_pkg::FrameBits'($urandom));
      end else begin
        send_req(1'($urandom_range(1)), $urandom, mlpt_pkg::FrameBits'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned phase_levels [8];
    int unsigned phase_widths [8][4];
    int unsigned w [4];
    phase_levels = '{2, 3, 4, 4, 1, 3, 4, 2};
    phase_widths = '{'{4, 4, 0, 0}, '{2, 3, 5, 0}, '{1, 1, 1, 1},
                     '{8, 8, 8, 8}, '{1, 0, 0, 0}, '{0, 0, 0, 0},
                     '{0, 0, 0, 0}, '{8, 8, 0, 0}};
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_req(mlpt_pkg::FuncLookup, 32'h0000_0000, 20'h00000);
    send_req(mlpt_pkg::FuncInsert, 32'h0000_0000, 20'hFFFFF);
    send_req(mlpt_pkg::FuncLookup, 32'h00FF_FFFF, 20'h00000);
    send_req(mlpt_pkg::FuncInsert, 32'hFFFF_FFFF, 20'h00000);
    send_req(mlpt_pkg::FuncLookup, 32'hFF00_0000, 20'hFFFFF);
    send_req(mlpt_pkg::FuncInsert, 32'h0100_0000, 20'h00005);
    send_req(mlpt_pkg::FuncLookup, 32'h8000_0000, 20'h00000);
    drain();
    configure(4, 8, 8, 8, 8);
    send_req(mlpt_pkg::FuncInsert, 32'h0000_0000, 20'hABCDE);
    send_req(mlpt_pkg::FuncLookup, 32'h0000_0000, 20'h00000);
    send_req(mlpt_pkg::FuncLookup, 32'h0000_0001, 20'h00000);
    send_req(mlpt_pkg::FuncInsert, 32'hFFFF_FFFF, 20'h12345);
    send_req(mlpt_pkg::FuncLookup, 32'hFFFF_FFFF, 20'h00000);
    send_req(mlpt_pkg::FuncLookup, 32'h0100_0000, 20'h00000);
    send_req(mlpt_pkg::FuncInsert, 32'h0123_4567, 20'h55555);
    drain();
    write_reg(mlpt_pkg::CfgLevelCount, 4'h0, 1'b1);
    send_req(mlpt_pkg::FuncLookup, 32'h0123_4567, 20'h00000);
    drain();
    write_reg(mlpt_pkg::CfgLevelCount, 4'hF, 1'b1);
    send_req(mlpt_pkg::FuncInsert, 32'h0123_4567, 20'hFFFFF);
    drain();
    write_reg(mlpt_pkg::CfgLevelCount, 4'hC, 1'b1);
    send_req(mlpt_pkg::FuncLookup, 32'h0123_4567, 20'h00000);
    drain();
    write_reg(mlpt_pkg::CfgLevel1Bits, 4'h0, 1'b1);
    send_req(mlpt_pkg::FuncInsert, 32'h0123_4567, 20'h00001);
    drain();
    write_reg(mlpt_pkg::CfgLevel1Bits, 4'h9, 1'b1);
    send_req(mlpt_pkg::FuncLookup, 32'h0123_4567, 20'h00000);
    drain();
    write_reg(mlpt_pkg::CfgLevel1Bits, 4'h8, 1'b0);
    write_reg(mlpt_pkg::CfgLevelCount, 4'h2, 1'b0);
    write_reg(mlpt_pkg::CfgLevel3Bits, 4'h0, 1'b1);
    send_req(mlpt_pkg::FuncLookup, 32'h0000_0000, 20'h00000);
    send_req(mlpt_pkg::FuncLookup, 32'h0000_FFFF, 20'h00000);
    drain();
    for (int unsigned k = 0; k < 3; k++)
      write_reg(CfgSpare + 3'(k), mlpt_pkg::CfgDataBits'($urandom_range(15)), k == 2);
    send_req(mlpt_pkg::FuncLookup, 32'h0123_4567, 20'h00000);
    drain();
    write_reg(mlpt_pkg::CfgLevelCount, 4'h5, 1'b1);
    send_req(mlpt_pkg::FuncLookup, 32'h0000_0000, 20'h00000);

    for (int unsigned p = 0; p < 8; p++) begin
      drain();
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 47;
      end else if (p < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int unsigned l = 0; l < 4; l++) begin
        if (l >= phase_levels[p]) w[l] = $urandom_range(15);
        else if (phase_widths[p][l] == 0) w[l] = $urandom_range(mlpt_pkg::MaxIndexBits, 1);
        else w[l] = phase_widths[p][l];
      end
      configure(phase_levels[p], w[0], w[1], w[2], w[3]);
      if (p == 3) hold_requests = hold_requests + 1;
      run_phase(PhaseItems);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_walks.size() == 0) begin
      $display("multi_level_page_table_core verification clean");
    end else begin
      $display("multi_level_page_table_core verification failed");
    end
    $finish;
  end

endmodule
